/* hdl/swpb_pkg.sv */
package swpb_pkg;

	// Sizing of the window store
	localparam int MAX_SLOTS = 16;
	localparam int PDU_WORDS = 512;

	// Fixed field widths
	localparam int SEQ_W   = 32;
	localparam int WIDX_W  = 9;
	localparam int DATA_W  = 32;
	localparam int BYTES_W = 12;
	localparam int CFG_W   = 5;

	// Derived widths
	localparam int SLOT_W    = (MAX_SLOTS > 1) ? $clog2(MAX_SLOTS) : 1;
	localparam int WIN_W     = SLOT_W + 1;
	localparam int SWP_CNT_W = $clog2(MAX_SLOTS + 1);
	localparam int PAY_DEPTH = MAX_SLOTS * PDU_WORDS;
	localparam int PAY_AW    = (PAY_DEPTH > 1) ? $clog2(PAY_DEPTH) : 1;

	// Slot index division: bits of the sequence number retired per cycle
	localparam int DIV_BITS  = 4;
	localparam int DIV_STEPS = SEQ_W / DIV_BITS;
	localparam int DIV_CNT_W = (DIV_STEPS > 1) ? $clog2(DIV_STEPS) : 1;

	// Window size after reset
	localparam logic [CFG_W-1:0] WIN_RESET = CFG_W'(16);

	// Request codes
	localparam logic [1:0] REQ_ADD = 2'd0;
	localparam logic [1:0] REQ_GET = 2'd1;
	localparam logic [1:0] REQ_RR  = 2'd2;

	// Status codes
	localparam logic [1:0] ST_OK      = 2'd0;
	localparam logic [1:0] ST_TAKEN   = 2'd1;
	localparam logic [1:0] ST_RR_HIGH = 2'd2;
	localparam logic [1:0] ST_RR_OLD  = 2'd3;

	typedef struct packed {
		logic [1:0]         req_type;
		logic [SEQ_W-1:0]   seq_num;
		logic [WIDX_W-1:0]  word_index;
		logic [DATA_W-1:0]  data_word;
		logic [BYTES_W-1:0] pdu_bytes;
		logic               pdu_last;
		logic [SEQ_W-1:0]   rr_number;
	} req_t;

	typedef struct packed {
		logic [1:0]         status_code;
		logic               window_open;
		logic               entry_valid;
		logic [SEQ_W-1:0]   entry_seq;
		logic [BYTES_W-1:0] entry_bytes;
		logic [DATA_W-1:0]  entry_word;
	} rsp_t;

	// One slot table entry
	typedef struct packed {
		logic [SEQ_W-1:0]   seq;
		logic [BYTES_W-1:0] bytes;
	} tbl_entry_t;

	// Sequencer states, one-hot
	typedef enum logic [6:0] {
		S_IDLE  = 7'b0000001,
		S_DIV   = 7'b0000010,
		S_READ  = 7'b0000100,
		S_EXEC  = 7'b0001000,
		S_RR    = 7'b0010000,
		S_SWEEP = 7'b0100000,
		S_DONE  = 7'b1000000
	} state_t;

endpackage

/* hdl/swpb_ram.sv */
module swpb_ram #(
	parameter int WIDTH = 32,
	parameter int DEPTH = 16
) (
	input  logic                                        clk,
	input  logic                                        we,
	input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
	input  logic [WIDTH-1:0]                            wdata,
	input  logic                                        re,
	input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
	output logic [WIDTH-1:0]                            rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	// One write port, one registered read port
	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem[raddr];
		end
	end

endmodule

/* hdl/swpb_slot_mod.sv */
module swpb_slot_mod import swpb_pkg::*; (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              go,
	input  logic [SEQ_W-1:0]  dividend,
	input  logic [WIN_W-1:0]  divisor,
	output logic              done,
	output logic [SLOT_W-1:0] rem
);

	logic [SEQ_W-1:0]     dvd_q;
	logic [WIN_W-1:0]     dsr_q;
	logic [SLOT_W-1:0]    rem_q;
	logic [DIV_CNT_W-1:0] cnt_q;
	logic                 run_q;
	logic                 done_q;
	logic [SLOT_W-1:0]    rem_nxt;

	// Restoring remainder, DIV_BITS dividend bits per cycle
	always_comb begin
		logic [WIN_W-1:0] t;
		rem_nxt = rem_q;
		for (int i = 0; i < DIV_BITS; i++) begin
			t = {rem_nxt, dvd_q[SEQ_W-1-i]};
			if (t >= dsr_q) begin
				t = t - dsr_q;
			end
			rem_nxt = t[SLOT_W-1:0];
		end
	end

	// Iteration control
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			run_q  <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (go) begin
				run_q <= 1'b1;
				cnt_q <= '0;
			end else if (run_q) begin
				cnt_q <= cnt_q + 1'b1;
				if (cnt_q == DIV_CNT_W'(DIV_STEPS - 1)) begin
					run_q  <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	// Operand and remainder registers
	always_ff @(posedge clk) begin
		if (go) begin
			dvd_q <= dividend;
			dsr_q <= divisor;
			rem_q <= '0;
		end else if (run_q) begin
			dvd_q <= dvd_q << DIV_BITS;
			rem_q <= rem_nxt;
		end
	end

	assign done = done_q;
	assign rem  = rem_q;

	// Remainder always below the divisor once finished
	a_rem_range: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> ({1'b0, rem_q} < dsr_q))
		else $error("slot remainder not below window size");

	// Done follows a running iteration
	a_done_src: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> $past(run_q))
		else $error("slot done without a running division");

	// No new start while dividing
	a_no_overlap: assert property (@(posedge clk) disable iff (!arst_n)
		run_q |-> !go)
		else $error("slot division restarted while running");

endmodule

/* hdl/sliding_window_pdu_buffer.sv */
// Channel   Handshake              Payload
// config    cfg_we                 cfg_wdata (window_size)
// request   start & !busy          req   (req_t)
// result    done, one cycle        result (rsp_t)
//
// Add/get: after acceptance the slot index is formed (modulo by window size, 4
// sequence bits per cycle), then capture, read, update, result. RR: straight to the
// result when rejected or ignored, else a slot table sweep, one entry per cycle
// through its single read port. Other codes likewise. Each result returns the block
// to idle. Reset clears slot valid flags, counters and window size (16); the payload
// RAM is not cleared. One item at a time; the receiver cannot stall.
module sliding_window_pdu_buffer import swpb_pkg::*; (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             cfg_we,
	input  logic [CFG_W-1:0] cfg_wdata,
	input  logic             start,
	input  req_t             req,
	output logic             busy,
	output logic             done,
	output rsp_t             result
);

	state_t                 state_q;
	logic [CFG_W-1:0]       win_size_q;
	logic [SEQ_W-1:0]       pdu_count_q;
	logic [SEQ_W-1:0]       last_rr_q;
	logic [MAX_SLOTS-1:0]   slot_valid_q;
	logic [MAX_SLOTS-1:0]   slot_wr_q;
	req_t                   req_q;
	rsp_t                   rsp_q;
	logic [SLOT_W-1:0]      slot_q;
	logic [SWP_CNT_W-1:0]   swp_cnt_q;
	logic                   swp_vld_s1;
	logic [SLOT_W-1:0]      swp_idx_s1;

	logic                   accept;
	logic [WIN_W-1:0]       win_eff;
	logic                   win_open;
	logic                   div_go;
	logic                   div_done;
	logic [SLOT_W-1:0]      div_rem;
	logic                   word_ok;
	logic [PAY_AW-1:0]      pay_addr;
	logic                   pay_we;
	logic                   pay_re;
	logic [DATA_W-1:0]      pay_rdata;
	logic                   tbl_we;
	logic                   tbl_re;
	logic [SLOT_W-1:0]      tbl_raddr;
	tbl_entry_t             tbl_wdata;
	logic [$bits(tbl_entry_t)-1:0] tbl_rraw;
	tbl_entry_t             tbl_rdata;
	logic [SEQ_W-1:0]       swp_seq;
	logic                   add_free;

	assign accept = start && !busy;
	assign busy   = (state_q != S_IDLE);
	assign done   = (state_q == S_DONE);

	// Clamped window size
	always_comb begin
		if (win_size_q == '0) begin
			win_eff = WIN_W'(1);
		end else if (int'(win_size_q) > MAX_SLOTS) begin
			win_eff = WIN_W'(MAX_SLOTS);
		end else begin
			win_eff = WIN_W'(win_size_q);
		end
	end

	// Window open: count below last RR plus window, no wrap
	assign win_open = ({1'b0, pdu_count_q} < ({1'b0, last_rr_q} + (SEQ_W + 1)'(win_eff)));

	always_comb begin
		result             = rsp_q;
		result.window_open = win_open;
	end

	// Slot index unit
	assign div_go = accept && (req.req_type == REQ_ADD || req.req_type == REQ_GET);

	swpb_slot_mod u_slot_mod (
		.clk      (clk),
		.arst_n   (arst_n),
		.go       (div_go),
		.dividend (req.seq_num),
		.divisor  (win_eff),
		.done     (div_done),
		.rem      (div_rem)
	);

	// Payload store
	assign word_ok  = int'(req_q.word_index) < PDU_WORDS;
	assign pay_addr = PAY_AW'(int'(slot_q) * PDU_WORDS + int'(req_q.word_index));
	assign add_free = !slot_valid_q[slot_q];
	assign pay_re   = (state_q == S_READ);
	assign pay_we   = (state_q == S_EXEC) && (req_q.req_type == REQ_ADD) && add_free && word_ok;

	swpb_ram #(
		.WIDTH (DATA_W),
		.DEPTH (PAY_DEPTH)
	) u_pay_ram (
		.clk   (clk),
		.we    (pay_we),
		.waddr (pay_addr),
		.wdata (req_q.data_word),
		.re    (pay_re),
		.raddr (pay_addr),
		.rdata (pay_rdata)
	);

	// Slot table: sequence number and size per slot, written on the last word
	assign tbl_we          = (state_q == S_EXEC) && (req_q.req_type == REQ_ADD) && add_free &&
	                         req_q.pdu_last;
	assign tbl_wdata.seq   = req_q.seq_num;
	assign tbl_wdata.bytes = req_q.pdu_bytes;
	assign tbl_re          = (state_q == S_READ) ||
	                         ((state_q == S_SWEEP) && (int'(swp_cnt_q) < MAX_SLOTS));
	assign tbl_raddr       = (state_q == S_SWEEP) ? swp_cnt_q[SLOT_W-1:0] : slot_q;
	assign tbl_rdata       = tbl_entry_t'(tbl_rraw);

	swpb_ram #(
		.WIDTH ($bits(tbl_entry_t)),
		.DEPTH (MAX_SLOTS)
	) u_tbl_ram (
		.clk   (clk),
		.we    (tbl_we),
		.waddr (slot_q),
		.wdata (tbl_wdata),
		.re    (tbl_re),
		.raddr (tbl_raddr),
		.rdata (tbl_rraw)
	);

	// Sweep compare operand: an entry never written reads as zero
	assign swp_seq = slot_wr_q[swp_idx_s1] ? tbl_rdata.seq : '0;

	// Sequencer and control state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q      <= S_IDLE;
			win_size_q   <= WIN_RESET;
			pdu_count_q  <= '0;
			last_rr_q    <= '0;
			slot_valid_q <= '0;
			slot_wr_q    <= '0;
			swp_cnt_q    <= '0;
			swp_vld_s1   <= 1'b0;
		end else begin
			if (cfg_we) begin
				win_size_q <= cfg_wdata;
			end
			case (state_q)
				S_IDLE: begin
					if (accept) begin
						case (req.req_type)
							REQ_ADD, REQ_GET: state_q <= S_DIV;
							REQ_RR:           state_q <= S_RR;
							default:          state_q <= S_DONE;
						endcase
					end
				end
				S_DIV: begin
					if (div_done) begin
						state_q <= S_READ;
					end
				end
				S_READ: begin
					state_q <= S_EXEC;
				end
				S_EXEC: begin
					if (tbl_we) begin
						slot_valid_q[slot_q] <= 1'b1;
						slot_wr_q[slot_q]    <= 1'b1;
						pdu_count_q          <= pdu_count_q + 1'b1;
					end
					state_q <= S_DONE;
				end
				S_RR: begin
					if (req_q.rr_number > pdu_count_q || req_q.rr_number <= last_rr_q) begin
						state_q <= S_DONE;
					end else begin
						swp_cnt_q  <= '0;
						swp_vld_s1 <= 1'b0;
						state_q    <= S_SWEEP;
					end
				end
				S_SWEEP: begin
					// issue stage
					if (int'(swp_cnt_q) < MAX_SLOTS) begin
						swp_cnt_q  <= swp_cnt_q + 1'b1;
						swp_vld_s1 <= 1'b1;
					end else begin
						swp_vld_s1 <= 1'b0;
					end
					// check stage: free slots below the RR
					if (swp_vld_s1 && slot_valid_q[swp_idx_s1] && swp_seq < req_q.rr_number) begin
						slot_valid_q[swp_idx_s1] <= 1'b0;
					end
					if (int'(swp_cnt_q) == MAX_SLOTS && !swp_vld_s1) begin
						last_rr_q <= req_q.rr_number;
						state_q   <= S_DONE;
					end
				end
				S_DONE: begin
					state_q <= S_IDLE;
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

	// Item, slot index and result registers
	always_ff @(posedge clk) begin
		if (accept) begin
			req_q <= req;
			rsp_q <= '0;
		end
		if (state_q == S_DIV && div_done) begin
			slot_q <= div_rem;
		end
		if (state_q == S_SWEEP) begin
			swp_idx_s1 <= swp_cnt_q[SLOT_W-1:0];
		end
		if (state_q == S_EXEC) begin
			if (req_q.req_type == REQ_ADD) begin
				rsp_q.status_code <= add_free ? ST_OK : ST_TAKEN;
			end else begin
				rsp_q.entry_valid <= slot_valid_q[slot_q];
				rsp_q.entry_seq   <= slot_wr_q[slot_q] ? tbl_rdata.seq : '0;
				rsp_q.entry_bytes <= slot_wr_q[slot_q] ? tbl_rdata.bytes : '0;
				rsp_q.entry_word  <= word_ok ? pay_rdata : '0;
			end
		end
		if (state_q == S_RR) begin
			if (req_q.rr_number > pdu_count_q) begin
				rsp_q.status_code <= ST_RR_HIGH;
			end else if (req_q.rr_number <= last_rr_q) begin
				rsp_q.status_code <= ST_RR_OLD;
			end
		end
	end

	// A valid slot has always had its table entry written
	a_valid_written: assert property (@(posedge clk) disable iff (!arst_n)
		(slot_valid_q & ~slot_wr_q) == '0)
		else $error("slot valid without a written table entry");

	// PDU count only ever steps by one
	a_count_step: assert property (@(posedge clk) disable iff (!arst_n)
		1'b1 |=> (pdu_count_q == $past(pdu_count_q) ||
		          pdu_count_q == $past(pdu_count_q) + 1'b1))
		else $error("pdu count jumped");

	// Last RR never moves backwards
	a_rr_mono: assert property (@(posedge clk) disable iff (!arst_n)
		1'b1 |=> (last_rr_q >= $past(last_rr_q)))
		else $error("last RR decreased");

	// Result strobe lasts one cycle and is followed by idle
	a_done_pulse: assert property (@(posedge clk) disable iff (!arst_n)
		done |=> (!done && !busy))
		else $error("result strobe longer than one cycle");

endmodule
